>>> rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define QDC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, live during reset as well
`define QDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/qdc_pkg.sv
// shared constants, types and codes of the readout word decoder
`default_nettype none
package qdc_pkg;

   localparam int NUM_CHANNELS = 16;

   localparam int WORD_W     = 32;
   localparam int CHARGE_W   = 16;
   localparam int ADC_W      = 12;
   localparam int CHANNEL_W  = 4;
   localparam int COUNT_W    = 23;
   localparam int SEQ_W      = 32;
   localparam int CNT_W      = $clog2(NUM_CHANNELS + 1);

   localparam logic [CHARGE_W-1:0] EMPTY_RESET = CHARGE_W'(9999);

   // word type codes, bits 26..24
   localparam int TYPE_LSB = 24;
   localparam int TYPE_W   = 3;
   localparam logic [TYPE_W-1:0] TYPE_DATA   = 3'b000;
   localparam logic [TYPE_W-1:0] TYPE_HEADER = 3'b010;
   localparam logic [TYPE_W-1:0] TYPE_EOB    = 3'b100;

   // data word fields
   localparam int CH_LSB    = 17;
   localparam int RANGE_BIT = 16;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;     // input word transfer this cycle
      logic emit_load;  // load next channel result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic eob_go;     // presented word is an end-of-block of an open event
      logic out_free;   // output register can take a result this cycle
      logic emit_last;  // channel being emitted is the final one
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/core/qdc_event_word_decoder.sv
// Readout word decoder for a 16-channel charge converter. Header, data and
// unused word types are taken one per clock while no end-of-block results
// are being emitted. An end-of-block word of an open event is taken and
// then yields 16 results, channel 0 to 15, read one per cycle from the
// charge register file into the single output register while rsp_stall does
// not hold it, and the input stalls until the last of them is loaded. The
// last result may wait in the output register while the next words are
// taken. empty_value is loaded into all channels by the next header.
`default_nettype none
module qdc_event_word_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [qdc_pkg::WORD_W-1:0]    req_word,
   input  wire logic                          csr_we,
   input  wire logic [qdc_pkg::CHARGE_W-1:0]  csr_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [qdc_pkg::CHANNEL_W-1:0]      rsp_channel,
   output logic [qdc_pkg::CHARGE_W-1:0]       rsp_charge,
   output logic                               rsp_range_flag,
   output logic [qdc_pkg::COUNT_W-1:0]        rsp_event_count,
   output logic [qdc_pkg::SEQ_W-1:0]          rsp_event_sequence,
   output logic                               rsp_last
);
   import qdc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   qdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qdc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_word           (req_word),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_channel        (rsp_channel),
      .rsp_charge         (rsp_charge),
      .rsp_range_flag     (rsp_range_flag),
      .rsp_event_count    (rsp_event_count),
      .rsp_event_sequence (rsp_event_sequence),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

>>> rtl/core/qdc_ctrl.sv
// controller: input acceptance and per-channel result sequencing
`default_nettype none
module qdc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire qdc_pkg::dp_status_type status,
   output qdc_pkg::ctrl_cmd_type     cmd
);
   import qdc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      cmd.accept    = 1'b0;
      cmd.emit_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.eob_go) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/qdc_dp.sv
// datapath: charge registers, event state, counters and the output register
`default_nettype none
module qdc_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [qdc_pkg::WORD_W-1:0]        req_word,
   input  wire logic                              csr_we,
   input  wire logic [qdc_pkg::CHARGE_W-1:0]      csr_wdata,
   input  wire qdc_pkg::ctrl_cmd_type             cmd,
   output qdc_pkg::dp_status_type                 status,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic [qdc_pkg::CHANNEL_W-1:0]          rsp_channel,
   output logic [qdc_pkg::CHARGE_W-1:0]           rsp_charge,
   output logic                                   rsp_range_flag,
   output logic [qdc_pkg::COUNT_W-1:0]            rsp_event_count,
   output logic [qdc_pkg::SEQ_W-1:0]              rsp_event_sequence,
   output logic                                   rsp_last
);
   import qdc_pkg::*;

   logic [CHARGE_W-1:0]  empty_value_ff;
   logic [CHARGE_W-1:0]  charges_ff [NUM_CHANNELS];
   logic                 event_open_ff;
   logic                 last_range_ff;
   logic [SEQ_W-1:0]     events_seen_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [CHANNEL_W-1:0] emit_idx_ff;

   logic                 out_valid_ff;
   logic [CHANNEL_W-1:0] out_channel_ff;
   logic [CHARGE_W-1:0]  out_charge_ff;
   logic                 out_range_ff;
   logic [COUNT_W-1:0]   out_count_ff;
   logic [SEQ_W-1:0]     out_seq_ff;
   logic                 out_last_ff;

   logic [TYPE_W-1:0]    word_type;
   logic [CHANNEL_W-1:0] word_ch;
   logic                 ch_ok;
   logic                 emit_last;

   assign word_type = req_word[TYPE_LSB +: TYPE_W];
   assign word_ch   = req_word[CH_LSB +: CHANNEL_W];
   assign ch_ok     = {1'b0, word_ch} < CNT_W'(NUM_CHANNELS);
   assign emit_last = emit_idx_ff == CHANNEL_W'(NUM_CHANNELS - 1);

   assign status.eob_go    = (word_type == TYPE_EOB) && event_open_ff;
   assign status.out_free  = !out_valid_ff || !rsp_stall;
   assign status.emit_last = emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_value_ff <= EMPTY_RESET;
      end else if (csr_we) begin
         empty_value_ff <= csr_wdata;
      end
   end

   // event state and charge registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            charges_ff[c] <= EMPTY_RESET;
         end
         event_open_ff  <= 1'b0;
         last_range_ff  <= 1'b0;
         events_seen_ff <= '0;
         emit_idx_ff    <= '0;
      end else begin
         if (cmd.accept) begin
            case (word_type)
               TYPE_HEADER: begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     charges_ff[c] <= empty_value_ff;
                  end
                  event_open_ff <= 1'b1;
               end
               TYPE_DATA: begin
                  if (ch_ok) begin
                     charges_ff[word_ch] <= CHARGE_W'(req_word[ADC_W-1:0]);
                     last_range_ff       <= !req_word[RANGE_BIT];
                  end
               end
               TYPE_EOB: begin
                  if (event_open_ff) begin
                     events_seen_ff <= events_seen_ff + SEQ_W'(1);
                     emit_idx_ff    <= '0;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.emit_load) begin
            emit_idx_ff <= emit_idx_ff + CHANNEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && status.eob_go) begin
         count_ff <= req_word[COUNT_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_channel_ff <= emit_idx_ff;
         out_charge_ff  <= charges_ff[emit_idx_ff];
         out_range_ff   <= last_range_ff;
         out_count_ff   <= count_ff;
         out_seq_ff     <= events_seen_ff;
         out_last_ff    <= emit_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_channel        = out_channel_ff;
   assign rsp_charge         = out_charge_ff;
   assign rsp_range_flag     = out_range_ff;
   assign rsp_event_count    = out_count_ff;
   assign rsp_event_sequence = out_seq_ff;
   assign rsp_last           = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/core/qdc_checker.sv
// port-level checker for the readout word decoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module qdc_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_stall,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [qdc_pkg::CHANNEL_W-1:0] rsp_channel,
   input  wire logic [qdc_pkg::CHARGE_W-1:0]  rsp_charge,
   input  wire logic                          rsp_range_flag,
   input  wire logic [qdc_pkg::COUNT_W-1:0]   rsp_event_count,
   input  wire logic [qdc_pkg::SEQ_W-1:0]     rsp_event_sequence,
   input  wire logic                          rsp_last
);
   import qdc_pkg::*;

   logic                                          rsp_xfer;
   logic [CHANNEL_W+CHARGE_W+COUNT_W+SEQ_W+1:0]   rsp_payload;

   assign rsp_xfer    = rsp_valid && !rsp_stall;
   assign rsp_payload = {rsp_channel, rsp_charge, rsp_range_flag, rsp_event_count,
                         rsp_event_sequence, rsp_last};

   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload);
   endproperty

   property p_last_chan;
      rsp_valid && rsp_last |-> rsp_channel == CHANNEL_W'(NUM_CHANNELS - 1);
   endproperty

   property p_next_chan;
      rsp_xfer && !rsp_last |=>
         rsp_valid && rsp_channel == $past(rsp_channel) + CHANNEL_W'(1);
   endproperty

   property p_in_block;
      rsp_valid && !rsp_last |-> req_stall;
   endproperty

   // a stalled result stays and holds its payload
   `QDC_ASSERT_RST(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result changed")

   `QDC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   `QDC_ASSERT_RST(a_last_chan, clock, reset, p_last_chan, "last flag off the final channel")

   // results of one event follow each other without a gap, channel by channel
   `QDC_ASSERT_RST(a_next_chan, clock, reset, p_next_chan, "channel sequence broken")

   // no input transfer while an event is still being emitted
   `QDC_ASSERT_RST(a_in_block, clock, reset, p_in_block, "input taken mid event")

endmodule

bind qdc_event_word_decoder qdc_checker u_qdc_checker (.*);
`default_nettype wire
